// ===== rtl/core/modinv_pkg.sv =====
// Shared constants, control word layout and microcode table for the modular inverse block.
package modinv_pkg;

   // Operand and datapath widths
   localparam int OPERAND_WIDTH = 32;
   localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
   localparam int PC_WIDTH      = 3;

   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

   typedef logic [PC_WIDTH-1:0] pc_type;
   typedef logic [2:0]          cond_type;
   typedef logic [2:0]          op_type;

   // Program addresses
   localparam pc_type P_IDLE    = 3'd0;
   localparam pc_type P_LOOP    = 3'd1;
   localparam pc_type P_DIVINIT = 3'd2;
   localparam pc_type P_DIVSTEP = 3'd3;
   localparam pc_type P_UPDATE  = 3'd4;
   localparam pc_type P_REDUCE  = 3'd5;
   localparam pc_type P_FINAL   = 3'd6;
   localparam pc_type P_RETURN  = 3'd7;

   // Jump conditions
   localparam cond_type C_NEVER    = 3'd0;
   localparam cond_type C_ALWAYS   = 3'd1;
   localparam cond_type C_REQ_NONE = 3'd2;
   localparam cond_type C_B_ZERO   = 3'd3;
   localparam cond_type C_CNT_NZ   = 3'd4;
   localparam cond_type C_OUT_BUSY = 3'd5;

   // Datapath operations
   localparam op_type OP_NONE    = 3'd0;
   localparam op_type OP_LOAD    = 3'd1;
   localparam op_type OP_DIVINIT = 3'd2;
   localparam op_type OP_DIVSTEP = 3'd3;
   localparam op_type OP_UPDATE  = 3'd4;
   localparam op_type OP_REDUCE  = 3'd5;
   localparam op_type OP_FINAL   = 3'd6;

   // One control word: jump if cond holds, else fall through.
   // With hold set, the op only executes when cond is false (wait steps).
   typedef struct packed {
      cond_type cond;
      pc_type   target;
      op_type   op;
      logic     hold;
   } ucode_type;

   // Microcode ROM
   function automatic ucode_type ucode_rom(input pc_type addr);
      ucode_type w;
      begin
         w = '{cond: C_NEVER, target: P_IDLE, op: OP_NONE, hold: 1'b0};
         unique case (addr)
            P_IDLE:    w = '{cond: C_REQ_NONE, target: P_IDLE,    op: OP_LOAD,    hold: 1'b1};
            P_LOOP:    w = '{cond: C_B_ZERO,   target: P_REDUCE,  op: OP_NONE,    hold: 1'b0};
            P_DIVINIT: w = '{cond: C_NEVER,    target: P_IDLE,    op: OP_DIVINIT, hold: 1'b0};
            P_DIVSTEP: w = '{cond: C_CNT_NZ,   target: P_DIVSTEP, op: OP_DIVSTEP, hold: 1'b0};
            P_UPDATE:  w = '{cond: C_ALWAYS,   target: P_LOOP,    op: OP_UPDATE,  hold: 1'b0};
            P_REDUCE:  w = '{cond: C_NEVER,    target: P_IDLE,    op: OP_REDUCE,  hold: 1'b0};
            P_FINAL:   w = '{cond: C_OUT_BUSY, target: P_FINAL,   op: OP_FINAL,   hold: 1'b1};
            P_RETURN:  w = '{cond: C_ALWAYS,   target: P_IDLE,    op: OP_NONE,    hold: 1'b0};
            default:   w = '{cond: C_ALWAYS,   target: P_IDLE,    op: OP_NONE,    hold: 1'b0};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== rtl/core/modular_inverse.sv =====
// Modular inverse by extended Euclid, run by a microcoded sequencer over a bit-serial divider.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   req     | in        | req_valid/req_stall | req_value, req_modulus
//   rsp     | out       | rsp_valid/rsp_stall | rsp_inverse, rsp_not_invertible
//
// Each of the n Euclid division steps (n up to about 47 for 32-bit operands) costs one
// restoring-division bit per cycle.
// One item is in flight at a time; req_stall is low only while the sequencer sits at idle.
// The result register lets the next item start while a result waits on rsp_stall.
// Synchronous active-high reset returns the sequencer to idle and drops rsp_valid.
module modular_inverse
   import modinv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OPERAND_WIDTH-1:0] req_value,
   input  logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OPERAND_WIDTH-1:0] rsp_inverse,
   output logic                     rsp_not_invertible
);

   // Sequencer
   pc_type    pc_ff, pc_in;
   ucode_type uw;
   logic      cond_true;
   logic      fire;

   // Datapath registers
   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] b_ff, b_in;
   logic [OPERAND_WIDTH-1:0] m_ff, m_in;
   logic [COEF_WIDTH-1:0]    u_ff, u_in;
   logic [COEF_WIDTH-1:0]    v_ff, v_in;
   logic [COEF_WIDTH-1:0]    t_ff, t_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] dq_ff, dq_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] r_ff, r_in;
   logic                     neg_ff, neg_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] rsp_inverse_ff, rsp_inverse_in;
   logic                     rsp_not_invertible_ff, rsp_not_invertible_in;

   // Divider and reduction helpers
   logic [COEF_WIDTH-1:0]    rem_sh;
   logic                     q_bit;
   logic [COEF_WIDTH-1:0]    rem_sub;
   logic [COEF_WIDTH-1:0]    mag;
   logic [COEF_WIDTH-1:0]    mag_sub;
   logic                     out_busy;

   assign uw       = ucode_rom(pc_ff);
   assign out_busy = rsp_valid_ff && rsp_stall;

   // Condition select
   always_comb begin
      unique case (uw.cond)
         C_NEVER:    cond_true = 1'b0;
         C_ALWAYS:   cond_true = 1'b1;
         C_REQ_NONE: cond_true = !req_valid;
         C_B_ZERO:   cond_true = (b_ff == '0);
         C_CNT_NZ:   cond_true = (cnt_ff != '0);
         C_OUT_BUSY: cond_true = out_busy;
         default:    cond_true = 1'b0;
      endcase
   end

   assign fire  = !(uw.hold && cond_true);
   assign pc_in = cond_true ? uw.target : pc_ff + pc_type'(1);

   // One restoring division bit; quotient bit also feeds the q*v Horner sum
   assign rem_sh  = {rem_ff, dq_ff[OPERAND_WIDTH-1]};
   assign rem_sub = rem_sh - {1'b0, b_ff};
   assign q_bit   = (rem_sh >= {1'b0, b_ff});

   // Magnitude of the final coefficient and its single reduction by m
   assign mag     = u_ff[COEF_WIDTH-1] ? ('0 - u_ff) : u_ff;
   assign mag_sub = mag - {1'b0, m_ff};

   // Datapath next state
   always_comb begin
      a_in                  = a_ff;
      b_in                  = b_ff;
      m_in                  = m_ff;
      u_in                  = u_ff;
      v_in                  = v_ff;
      t_in                  = t_ff;
      rem_in                = rem_ff;
      dq_in                 = dq_ff;
      cnt_in                = cnt_ff;
      r_in                  = r_ff;
      neg_in                = neg_ff;
      rsp_inverse_in        = rsp_inverse_ff;
      rsp_not_invertible_in = rsp_not_invertible_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      if (fire) begin
         unique case (uw.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
               a_in = req_value;
               b_in = req_modulus;
               m_in = req_modulus;
               u_in = COEF_WIDTH'(1);
               v_in = '0;
            end
            OP_DIVINIT: begin
               rem_in = '0;
               dq_in  = a_ff;
               t_in   = '0;
               cnt_in = CNT_LAST;
            end
            OP_DIVSTEP: begin
               rem_in = q_bit ? rem_sub[OPERAND_WIDTH-1:0] : rem_sh[OPERAND_WIDTH-1:0];
               dq_in  = {dq_ff[OPERAND_WIDTH-2:0], 1'b0};
               t_in   = {t_ff[COEF_WIDTH-2:0], 1'b0} + (q_bit ? v_ff : '0);
               cnt_in = cnt_ff - CNT_WIDTH'(1);
            end
            OP_UPDATE: begin
               a_in = b_ff;
               b_in = rem_ff;
               u_in = v_ff;
               v_in = u_ff - t_ff;
            end
            OP_REDUCE: begin
               neg_in = u_ff[COEF_WIDTH-1];
               r_in   = (mag >= {1'b0, m_ff}) ? mag_sub[OPERAND_WIDTH-1:0]
                                              : mag[OPERAND_WIDTH-1:0];
            end
            OP_FINAL: begin
               if (m_ff == '0) begin
                  rsp_inverse_in = '0;
               end else if (neg_ff && (r_ff != '0)) begin
                  rsp_inverse_in = m_ff - r_ff;
               end else begin
                  rsp_inverse_in = r_ff;
               end
               rsp_not_invertible_in = (m_ff == '0) || (a_ff != OPERAND_WIDTH'(1));
               rsp_valid_in          = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff                  <= a_in;
      b_ff                  <= b_in;
      m_ff                  <= m_in;
      u_ff                  <= u_in;
      v_ff                  <= v_in;
      t_ff                  <= t_in;
      rem_ff                <= rem_in;
      dq_ff                 <= dq_in;
      cnt_ff                <= cnt_in;
      r_ff                  <= r_in;
      neg_ff                <= neg_in;
      rsp_inverse_ff        <= rsp_inverse_in;
      rsp_not_invertible_ff <= rsp_not_invertible_in;
   end

   assign req_stall          = (pc_ff != P_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inverse        = rsp_inverse_ff;
   assign rsp_not_invertible = rsp_not_invertible_ff;

   // Checks
   a_final_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (fire && (uw.op == OP_FINAL)) |=> rsp_valid)
      else $error("result not presented after final step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == P_DIVSTEP) |-> (rem_ff < b_ff))
      else $error("partial remainder not below divisor");

   a_update_after_div: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == P_UPDATE) |-> ($past(pc_ff) == P_DIVSTEP) && ($past(cnt_ff) == '0))
      else $error("update reached before division finished");

endmodule
